// ===== hw/rtl/htw_pkg.sv =====
package htw_pkg;

    localparam int SLOT_BITS   = 8;
    localparam int LEVELS      = 4;
    localparam int TIMER_COUNT = 64;
    localparam int TIME_W      = 32;

    localparam int SLOTS      = LEVELS << SLOT_BITS;
    localparam int SLOT_IDX_W = $clog2(SLOTS);
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ID_W       = $clog2(TIMER_COUNT + 1);
    localparam int TID_W      = $clog2(TIMER_COUNT);

    // Link value that marks an empty slot or the end of a list.
    localparam logic [ID_W-1:0] ID_NONE = ID_W'(TIMER_COUNT);

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_TICK  = 2'd2
    } act_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_UNLINK,
        OP_START,
        OP_WALK_SLOT,
        OP_TAKE,
        OP_CASC,
        OP_EMIT,
        OP_NEXT,
        OP_PSLOT,
        OP_APPEND,
        OP_LINK,
        OP_LVL_DEC
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_WAIT,
        ST_UNLINK,
        ST_START,
        ST_P_SLOT,
        ST_P_RD,
        ST_P_APP,
        ST_P_LINK,
        ST_T_LVL,
        ST_W_RD,
        ST_W_TAKE,
        ST_W_WAIT,
        ST_W_ITEM,
        ST_W_NEXT,
        ST_T_NEXT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_act;
        logic       in_id_ok;
        logic       clr_last;
        logic       is_start;
        logic       is_tick;
        logic       lvl_zero;
        logic       low_zero;
        logic       head_none;
        logic       nxt_none;
        logic       per;
        logic       out_free;
    } sts_t;

    // Digit of a time value at a given level; zero once the level lies above bit 31.
    function automatic logic [SLOT_BITS-1:0] digit_of(logic [TIME_W-1:0] t, int unsigned l);
        logic [63:0] w;
        w = {32'b0, t} >> (l * SLOT_BITS);
        return w[SLOT_BITS-1:0];
    endfunction

    // Slot a timer belongs in: the lowest level whose range covers the delay.
    function automatic logic [SLOT_IDX_W-1:0] slot_of(logic [TIME_W-1:0] expv,
                                                      logic [TIME_W-1:0] ct);
        logic [TIME_W-1:0]    delta;
        logic [LVL_W-1:0]     lvl;
        logic                 stop;
        logic [SLOT_BITS-1:0] dig;
        logic [63:0]          dw;
        delta = expv - ct;
        lvl   = '0;
        stop  = 1'b0;
        for (int l = 1; l < LEVELS; l++) begin
            dw = {32'b0, delta} >> (l * SLOT_BITS);
            if (!stop) begin
                if (dw == 64'd0) stop = 1'b1;
                else lvl = LVL_W'(l);
            end
        end
        dig = digit_of(expv, 0);
        for (int l = 1; l < LEVELS; l++) begin
            if (lvl == LVL_W'(l)) dig = digit_of(expv, l);
        end
        return SLOT_IDX_W'({lvl, dig});
    endfunction

    // True when all digits below the given level are zero.
    function automatic logic low_zero_of(logic [TIME_W-1:0] t, logic [LVL_W-1:0] lvl);
        logic        res;
        logic [63:0] m;
        res = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            if (lvl == LVL_W'(l)) begin
                m   = (64'd1 << (l * SLOT_BITS)) - 64'd1;
                res = (({32'b0, t} & m) == 64'd0);
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/htw_ctrl.sv =====
module htw_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  htw_pkg::sts_t   sts,
    output htw_pkg::cmd_t   cmd,
    output logic            s_tready
);

    htw_pkg::state_t state_reg, state_next;
    htw_pkg::state_t ret_st, done_st;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= htw_pkg::ST_CLEAR;
        else state_reg <= state_next;
    end

    always_comb begin
        ret_st     = sts.is_tick ? htw_pkg::ST_W_NEXT : htw_pkg::ST_IDLE;
        done_st    = sts.lvl_zero ? htw_pkg::ST_IDLE : htw_pkg::ST_T_NEXT;
        state_next = state_reg;
        cmd.op     = htw_pkg::OP_IDLE;
        s_tready   = 1'b0;
        case (state_reg)
            htw_pkg::ST_CLEAR: begin
                cmd.op = htw_pkg::OP_CLEAR;
                if (sts.clr_last) state_next = htw_pkg::ST_IDLE;
            end
            htw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = htw_pkg::OP_ACCEPT;
                    case (sts.in_act)
                        htw_pkg::ACT_START, htw_pkg::ACT_STOP: begin
                            if (sts.in_id_ok) state_next = htw_pkg::ST_ACC_WAIT;
                        end
                        htw_pkg::ACT_TICK: state_next = htw_pkg::ST_T_LVL;
                        default: state_next = htw_pkg::ST_IDLE;
                    endcase
                end
            end
            htw_pkg::ST_ACC_WAIT: state_next = htw_pkg::ST_UNLINK;
            htw_pkg::ST_UNLINK: begin
                cmd.op     = htw_pkg::OP_UNLINK;
                state_next = sts.is_start ? htw_pkg::ST_START : htw_pkg::ST_IDLE;
            end
            htw_pkg::ST_START: begin
                cmd.op     = htw_pkg::OP_START;
                state_next = htw_pkg::ST_P_SLOT;
            end
            htw_pkg::ST_P_SLOT: begin
                cmd.op     = htw_pkg::OP_PSLOT;
                state_next = htw_pkg::ST_P_RD;
            end
            htw_pkg::ST_P_RD: state_next = htw_pkg::ST_P_APP;
            htw_pkg::ST_P_APP: begin
                cmd.op     = htw_pkg::OP_APPEND;
                state_next = sts.head_none ? ret_st : htw_pkg::ST_P_LINK;
            end
            htw_pkg::ST_P_LINK: begin
                cmd.op     = htw_pkg::OP_LINK;
                state_next = ret_st;
            end
            htw_pkg::ST_T_LVL: begin
                if (sts.lvl_zero || sts.low_zero) begin
                    cmd.op     = htw_pkg::OP_WALK_SLOT;
                    state_next = htw_pkg::ST_W_RD;
                end else begin
                    cmd.op = htw_pkg::OP_LVL_DEC;
                end
            end
            htw_pkg::ST_W_RD: state_next = htw_pkg::ST_W_TAKE;
            htw_pkg::ST_W_TAKE: begin
                cmd.op     = htw_pkg::OP_TAKE;
                state_next = sts.head_none ? done_st : htw_pkg::ST_W_WAIT;
            end
            htw_pkg::ST_W_WAIT: state_next = htw_pkg::ST_W_ITEM;
            htw_pkg::ST_W_ITEM: begin
                if (sts.lvl_zero) begin
                    if (sts.out_free) begin
                        cmd.op     = htw_pkg::OP_EMIT;
                        state_next = sts.per ? htw_pkg::ST_P_SLOT : htw_pkg::ST_W_NEXT;
                    end
                end else begin
                    cmd.op     = htw_pkg::OP_CASC;
                    state_next = htw_pkg::ST_P_SLOT;
                end
            end
            htw_pkg::ST_W_NEXT: begin
                cmd.op     = htw_pkg::OP_NEXT;
                state_next = sts.nxt_none ? done_st : htw_pkg::ST_W_WAIT;
            end
            htw_pkg::ST_T_NEXT: begin
                cmd.op     = htw_pkg::OP_LVL_DEC;
                state_next = htw_pkg::ST_T_LVL;
            end
            default: state_next = htw_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/htw_dpath.sv =====
module htw_dpath (
    input  logic            aclk,
    input  logic            aresetn,
    input  htw_pkg::cmd_t   cmd,
    input  logic [39:0]     s_tdata,
    input  logic [1:0]      s_tuser,
    input  logic            m_tready,
    output htw_pkg::sts_t   sts,
    output logic            m_tvalid,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    localparam int IW = htw_pkg::ID_W;
    localparam int TW = htw_pkg::TIME_W;
    localparam int SW = htw_pkg::SLOT_IDX_W;
    localparam int KW = htw_pkg::TID_W;

    // Slot memories and per-timer memories.
    logic [IW-1:0] head_mem [htw_pkg::SLOTS];
    logic [IW-1:0] tail_mem [htw_pkg::SLOTS];
    logic [IW-1:0] next_mem [htw_pkg::TIMER_COUNT];
    logic [IW-1:0] prev_mem [htw_pkg::TIMER_COUNT];
    logic [TW-1:0] exp_mem  [htw_pkg::TIMER_COUNT];
    logic [TW-1:0] rel_mem  [htw_pkg::TIMER_COUNT];
    logic          per_mem  [htw_pkg::TIMER_COUNT];
    logic [SW-1:0] home_mem [htw_pkg::TIMER_COUNT];

    logic [htw_pkg::TIMER_COUNT-1:0] active_reg;

    logic [IW-1:0] head_q, tail_q, next_q, prev_q;
    logic [TW-1:0] exp_q, rel_q;
    logic          per_q;
    logic [SW-1:0] home_q;

    logic [TW-1:0]              ct_reg;
    logic [SW-1:0]              clr_reg;
    logic [SW-1:0]              slot_reg;
    logic [IW-1:0]              id_reg, nxt_reg, link_reg;
    logic [TW-1:0]              exp_reg, intv_reg;
    logic                       per_reg;
    logic [1:0]                 act_reg;
    logic [htw_pkg::LVL_W-1:0]  lvl_reg;
    logic                       m_tvalid_reg;
    logic [IW-1:0]              m_id_reg;
    logic                       m_last_reg;

    logic [KW-1:0] id_idx;
    logic          out_free;
    logic          cur_active;
    logic [TW-1:0] sum_start, sum_rearm;

    logic          head_we, tail_we, next_we, prev_we, exp_we;
    logic [SW-1:0] head_wa, tail_wa;
    logic [IW-1:0] head_wd, tail_wd, next_wd, prev_wd;
    logic [KW-1:0] next_wa, prev_wa;
    logic [TW-1:0] exp_wd;

    assign id_idx     = id_reg[KW-1:0];
    assign out_free   = !m_tvalid_reg || m_tready;
    assign cur_active = active_reg[id_idx];
    assign sum_start  = ct_reg + intv_reg;
    assign sum_rearm  = ct_reg + rel_q;

    always_comb begin
        sts.in_act    = s_tuser;
        sts.in_id_ok  = (32'(s_tdata[5:0]) < 32'(htw_pkg::TIMER_COUNT));
        sts.clr_last  = (clr_reg == SW'(htw_pkg::SLOTS - 1));
        sts.is_start  = (act_reg == htw_pkg::ACT_START);
        sts.is_tick   = (act_reg == htw_pkg::ACT_TICK);
        sts.lvl_zero  = (lvl_reg == '0);
        sts.low_zero  = htw_pkg::low_zero_of(ct_reg, lvl_reg);
        sts.head_none = (head_q == htw_pkg::ID_NONE);
        sts.nxt_none  = (nxt_reg == htw_pkg::ID_NONE);
        sts.per       = per_q;
        sts.out_free  = out_free;
    end

    // Write port selection for the list memories.
    always_comb begin
        head_we = 1'b0; head_wa = slot_reg; head_wd = htw_pkg::ID_NONE;
        tail_we = 1'b0; tail_wa = slot_reg; tail_wd = id_reg;
        next_we = 1'b0; next_wa = id_idx;   next_wd = htw_pkg::ID_NONE;
        prev_we = 1'b0; prev_wa = id_idx;   prev_wd = htw_pkg::ID_NONE;
        exp_we  = 1'b0; exp_wd  = sum_start;
        case (cmd.op)
            htw_pkg::OP_CLEAR: begin
                head_we = 1'b1;
                head_wa = clr_reg;
            end
            htw_pkg::OP_UNLINK: begin
                if (cur_active) begin
                    if (prev_q == htw_pkg::ID_NONE) begin
                        head_we = 1'b1;
                        head_wa = home_q;
                        head_wd = next_q;
                    end else begin
                        next_we = 1'b1;
                        next_wa = prev_q[KW-1:0];
                        next_wd = next_q;
                    end
                    if (next_q == htw_pkg::ID_NONE) begin
                        tail_we = 1'b1;
                        tail_wa = home_q;
                        tail_wd = prev_q;
                    end else begin
                        prev_we = 1'b1;
                        prev_wa = next_q[KW-1:0];
                        prev_wd = prev_q;
                    end
                end
            end
            htw_pkg::OP_START: exp_we = 1'b1;
            htw_pkg::OP_TAKE: head_we = 1'b1;
            htw_pkg::OP_EMIT: begin
                exp_we = per_q;
                exp_wd = sum_rearm;
            end
            htw_pkg::OP_APPEND: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                prev_wd = (head_q == htw_pkg::ID_NONE) ? htw_pkg::ID_NONE : tail_q;
                tail_we = 1'b1;
                if (head_q == htw_pkg::ID_NONE) begin
                    head_we = 1'b1;
                    head_wd = id_reg;
                end
            end
            htw_pkg::OP_LINK: begin
                next_we = 1'b1;
                next_wa = link_reg[KW-1:0];
                next_wd = id_reg;
            end
            default: head_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_q <= head_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (tail_we) tail_mem[tail_wa] <= tail_wd;
        tail_q <= tail_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        next_q <= next_mem[id_idx];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        prev_q <= prev_mem[id_idx];
    end

    always_ff @(posedge aclk) begin
        if (exp_we) exp_mem[id_idx] <= exp_wd;
        exp_q <= exp_mem[id_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == htw_pkg::OP_START) begin
            rel_mem[id_idx] <= intv_reg;
            per_mem[id_idx] <= per_reg;
        end
        rel_q <= rel_mem[id_idx];
        per_q <= per_mem[id_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == htw_pkg::OP_APPEND) home_mem[id_idx] <= slot_reg;
        home_q <= home_mem[id_idx];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= '0;
            ct_reg       <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.op == htw_pkg::OP_CLEAR) clr_reg <= clr_reg + SW'(1);
            if (cmd.op == htw_pkg::OP_UNLINK) active_reg[id_idx] <= 1'b0;
            if (cmd.op == htw_pkg::OP_START) active_reg[id_idx] <= 1'b1;
            if (cmd.op == htw_pkg::OP_EMIT && !per_q) active_reg[id_idx] <= 1'b0;
            if (cmd.op == htw_pkg::OP_TAKE && lvl_reg == '0) ct_reg <= ct_reg + TW'(1);
            if (cmd.op == htw_pkg::OP_EMIT) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            htw_pkg::OP_ACCEPT: begin
                id_reg   <= IW'(s_tdata[5:0]);
                intv_reg <= s_tdata[37:6];
                per_reg  <= s_tdata[38];
                act_reg  <= s_tuser;
                lvl_reg  <= htw_pkg::LVL_W'(htw_pkg::LEVELS - 1);
            end
            htw_pkg::OP_START: exp_reg <= sum_start;
            htw_pkg::OP_WALK_SLOT: slot_reg <= SW'({lvl_reg,
                                        htw_pkg::digit_of(ct_reg, 32'(lvl_reg))});
            htw_pkg::OP_TAKE: id_reg <= head_q;
            htw_pkg::OP_CASC: begin
                nxt_reg <= next_q;
                exp_reg <= exp_q;
            end
            htw_pkg::OP_EMIT: begin
                nxt_reg    <= next_q;
                exp_reg    <= sum_rearm;
                m_id_reg   <= id_reg;
                m_last_reg <= (next_q == htw_pkg::ID_NONE);
            end
            htw_pkg::OP_NEXT: id_reg <= nxt_reg;
            htw_pkg::OP_PSLOT: slot_reg <= htw_pkg::slot_of(exp_reg, ct_reg);
            htw_pkg::OP_APPEND: link_reg <= tail_q;
            htw_pkg::OP_LVL_DEC: lvl_reg <= lvl_reg - htw_pkg::LVL_W'(1);
            default: link_reg <= link_reg;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, 6'(m_id_reg)};
    assign m_tlast  = m_last_reg;

endmodule

// ===== hw/rtl/hierarchical_timer_wheel.sv =====
// Channel  Direction  Beat contents
// s_       in         tuser[1:0] action; tdata[5:0] timer_id, [37:6] interval, [38] periodic
// m_       out        tdata[5:0] expired_id; tlast marks the final expiry of a tick
//
// A stop runs accept, a read wait and unlink; a start adds start, slot choice, a read wait,
// append and, if the slot held timers, link; the waits suit the registered memory reads.
// A tick walks level 0 and each upper level whose lower digits of time are zero, cascading
// or emitting each timer and re-placing periodic ones. After reset a clearing pass empties
// all 1024 slot heads and no beat is accepted until it ends. A stalled result holds the
// walk in place; once it ends, the output keeps the last expiry while new beats are taken.
module hierarchical_timer_wheel (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [5:0] timer_id, [37:6] interval, [38] periodic
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] expired_id
    output logic        m_tlast
);

    // The controller sequences list walks and placements; the datapath owns
    // the slot and timer memories, the current time and the output register.
    htw_pkg::cmd_t cmd;
    htw_pkg::sts_t sts;

    htw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    htw_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
